// ===== rtl/ddg_pkg.sv =====
// ddg_pkg: shared constants, types and tables of the direction dispersion gain unit.
// No dependencies; every other file imports it.
`default_nettype none
package ddg_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int IDX_W         = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int PAIRS         = HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2;

    localparam int POS_W    = 16;
    localparam int ANGLE_W  = 16;
    localparam int SPREAD_W = 16;
    localparam int GAIN_W   = 27;
    localparam int DIST_W   = 15;
    localparam int SIM_W    = 17;

    localparam int TOTAL_W  = $clog2(PAIRS * 65536 + 1);
    localparam int CUR_W    = $clog2((HISTORY_DEPTH - 1) * 65536 + 1);
    localparam int PROD_W   = TOTAL_W + CUR_W;

    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_W     = 27;
    localparam int Z_W          = 17;
    localparam int LOG2E_Q16    = 94548;
    localparam int SPREAD_RESET = 410;
    localparam longint GAIN_MAX = (64'd1 << GAIN_W) - 64'd1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_ALL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_NEW = 1'd1;

    // cycles from the last pair issued until the accumulators are settled
    localparam int DRAIN_CYCLES = 7;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    typedef struct packed {
        logic             load_in;
        logic             cordic_step;
        logic [3:0]       step_idx;
        logic             store_write;
        logic             issue;
        logic             new_pass;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        logic             mul;
        logic             emit;
    } ddg_cmd_t;

    typedef struct packed {
        logic out_free;
    } ddg_status_t;

    // arctan(2^-i) in 1/128 degree
    function automatic logic [12:0] atan_lut(input logic [3:0] i);
        logic [12:0] v;
        case (i)
            4'd0:    v = 13'd5760;
            4'd1:    v = 13'd3400;
            4'd2:    v = 13'd1797;
            4'd3:    v = 13'd912;
            4'd4:    v = 13'd458;
            4'd5:    v = 13'd229;
            4'd6:    v = 13'd115;
            4'd7:    v = 13'd57;
            4'd8:    v = 13'd29;
            4'd9:    v = 13'd14;
            4'd10:   v = 13'd7;
            4'd11:   v = 13'd4;
            4'd12:   v = 13'd2;
            4'd13:   v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // 2^16 * 2^(-j/16)
    function automatic logic [16:0] pow2_lut(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40694;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34220;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ddg_if.sv =====
// ddg_if: valid/ready channel interfaces for source positions and gain results.
// Depends on ddg_pkg.
`default_nettype none
interface ddg_pos_if
    import ddg_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface ddg_gain_if
    import ddg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;

    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddg_decay.sv =====
// ddg_decay: four-stage pipelined exp(-k*d) in Q1.16, table based.
// Depends on ddg_pkg.
`default_nettype none
module ddg_decay
    import ddg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    input  wire logic                op_new,
    input  wire logic [SPREAD_W-1:0] k,
    input  wire logic [DIST_W-1:0]   d,
    output logic                     res_valid,
    output logic                     res_new,
    output logic [SIM_W-1:0]         res_val
);
    logic [3:0]  valid_reg;
    logic [3:0]  new_reg;
    logic [30:0] e_reg;
    logic [47:0] p_reg;
    logic [16:0] m_reg;
    logic [4:0]  n_reg;
    logic        zero_reg;
    logic [SIM_W-1:0] val_reg;

    logic [48:0] p_rnd;
    logic [21:0] w;
    logic [4:0]  j;
    logic [3:0]  r;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [15:0] slope;
    logic [16:0] m_next;
    logic [17:0] m_rnd;
    logic [17:0] m_sh;

    always_comb
    begin
        p_rnd  = {1'b0, p_reg} + 49'(64'd1 << 26);
        w      = p_rnd[48:27];
        j      = {1'b0, w[7:4]};
        r      = w[3:0];
        t0     = pow2_lut(j);
        t1     = pow2_lut(j + 5'd1);
        slope  = 16'((t0 - t1) * r) + 16'd8;
        m_next = t0 - 17'(slope[15:4]);
        m_rnd  = {1'b0, m_reg} + ((n_reg == 5'd0) ? 18'd0 : (18'd1 << (n_reg - 5'd1)));
        m_sh   = m_rnd >> n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], op_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg  <= {new_reg[2:0], op_new};
        e_reg    <= 31'(k * d);
        p_reg    <= 48'(e_reg * 17'(LOG2E_Q16));
        m_reg    <= m_next;
        n_reg    <= w[12:8];
        zero_reg <= (w[21:8] >= 14'd17);
        val_reg  <= zero_reg ? '0 : SIM_W'(m_sh);
    end

    assign res_valid = valid_reg[3];
    assign res_new   = new_reg[3];
    assign res_val   = val_reg;
endmodule
`default_nettype wire

// ===== rtl/ddg_datapath.sv =====
// ddg_datapath: CORDIC registers, angle store, distance, decay, sums, output register.
// Depends on ddg_pkg and ddg_decay.
`default_nettype none
module ddg_datapath
    import ddg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [SPREAD_W-1:0]     cfg_data,
    input  wire ddg_cmd_t                cmd,
    output ddg_status_t                  status,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [GAIN_W-1:0]            gain
);
    localparam int RND_W = PROD_W - 15;
    localparam int SAT_W = (RND_W > GAIN_W) ? RND_W + 1 : GAIN_W + 1;

    logic [SPREAD_W-1:0] spread_all_reg;
    logic [SPREAD_W-1:0] spread_new_reg;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic                       zero_reg;

    logic [ANGLE_W-1:0]       store_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] written_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic [IDX_W-1:0]         slot_next;

    logic signed [ANGLE_W-1:0] rd_a_reg;
    logic signed [ANGLE_W-1:0] rd_b_reg;
    logic                      rd_valid_reg;
    logic                      rd_new_reg;

    logic [TOTAL_W-1:0] total_reg;
    logic [CUR_W-1:0]   cur_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    logic [GAIN_W-1:0]  gain_reg;

    logic signed [POS_W:0]      x0;
    logic signed [POS_W:0]      y0;
    logic signed [Z_W-1:0]      z0;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [Z_W-1:0]      step_z;
    logic signed [Z_W-1:0]      z_wrap;
    logic [ANGLE_W-1:0]         angle;
    logic [IDX_W-1:0]           rd_addr_a;
    logic                       op_valid;
    logic signed [ANGLE_W:0]    diff;
    logic [ANGLE_W:0]           dist_abs;
    logic [DIST_W-1:0]          pair_dist;
    logic [SPREAD_W-1:0]        k_sel;
    logic                       res_valid;
    logic                       res_new;
    logic [SIM_W-1:0]           res_val;
    logic [PROD_W:0]            prod_rnd;
    logic [SAT_W-1:0]           gain_wide;

    // pre-rotation by a quarter turn for the left half plane
    always_comb
    begin
        x0 = {pos_x[POS_W-1], pos_x};
        y0 = {pos_y[POS_W-1], pos_y};
        z0 = '0;
        if (pos_x[POS_W-1])
        begin
            if (!pos_y[POS_W-1])
            begin
                x0 = {pos_y[POS_W-1], pos_y};
                y0 = -{pos_x[POS_W-1], pos_x};
                z0 = Z_W'(QUARTER_TURN);
            end
            else
            begin
                x0 = -{pos_y[POS_W-1], pos_y};
                y0 = {pos_x[POS_W-1], pos_x};
                z0 = -Z_W'(QUARTER_TURN);
            end
        end
    end

    always_comb
    begin
        dx     = y_reg >>> cmd.step_idx;
        dy     = x_reg >>> cmd.step_idx;
        step_z = Z_W'(atan_lut(cmd.step_idx));
        z_wrap = z_reg;
        if (z_reg > Z_W'(HALF_TURN))
        begin
            z_wrap = z_reg - Z_W'(FULL_TURN);
        end
        else if (z_reg < -Z_W'(HALF_TURN))
        begin
            z_wrap = z_reg + Z_W'(FULL_TURN);
        end
        angle     = zero_reg ? '0 : ANGLE_W'(z_wrap);
        slot_next = (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg    <= CORDIC_W'(x0) <<< 8;
            y_reg    <= CORDIC_W'(y0) <<< 8;
            z_reg    <= z0;
            zero_reg <= (pos_x == '0) && (pos_y == '0);
        end
        else if (cmd.cordic_step)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step_z;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step_z;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_all_reg <= SPREAD_W'(SPREAD_RESET);
            spread_new_reg <= SPREAD_W'(SPREAD_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPREAD_ALL: spread_all_reg <= cfg_data;
                REG_SPREAD_NEW: spread_new_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // angle store: entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.store_write)
        begin
            store_mem[slot_next] <= angle;
        end
    end

    assign rd_addr_a = cmd.new_pass ? slot_reg : cmd.addr_a;
    assign op_valid  = cmd.issue && !(cmd.new_pass && (cmd.addr_b == slot_reg));

    always_ff @(posedge clk)
    begin
        rd_a_reg   <= written_reg[rd_addr_a] ? store_mem[rd_addr_a] : '0;
        rd_b_reg   <= written_reg[cmd.addr_b] ? store_mem[cmd.addr_b] : '0;
        rd_new_reg <= cmd.new_pass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            slot_reg     <= IDX_W'(HISTORY_DEPTH - 1);
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= op_valid;
            if (cmd.store_write)
            begin
                written_reg[slot_next] <= 1'b1;
                slot_reg               <= slot_next;
            end
        end
    end

    // circular distance, at most half a turn
    always_comb
    begin
        diff      = {rd_a_reg[ANGLE_W-1], rd_a_reg} - {rd_b_reg[ANGLE_W-1], rd_b_reg};
        dist_abs  = diff[ANGLE_W] ? ANGLE_W'(0) - diff : diff;
        pair_dist = (dist_abs > (ANGLE_W + 1)'(HALF_TURN))
                  ? DIST_W'((ANGLE_W + 1)'(FULL_TURN) - dist_abs) : DIST_W'(dist_abs);
        k_sel     = rd_new_reg ? spread_new_reg : spread_all_reg;
    end

    ddg_decay u_decay (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (rd_valid_reg),
        .op_new    (rd_new_reg),
        .k         (k_sel),
        .d         (pair_dist),
        .res_valid (res_valid),
        .res_new   (res_new),
        .res_val   (res_val)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            total_reg <= '0;
            cur_reg   <= '0;
        end
        else if (res_valid)
        begin
            if (res_new)
            begin
                cur_reg <= cur_reg + CUR_W'(res_val);
            end
            else
            begin
                total_reg <= total_reg + TOTAL_W'(res_val);
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(total_reg * cur_reg);
        end
    end

    always_comb
    begin
        prod_rnd  = {1'b0, prod_reg} + (PROD_W + 1)'(32768);
        gain_wide = SAT_W'(prod_rnd[PROD_W:16]);
        if (gain_wide > SAT_W'(GAIN_MAX))
        begin
            gain_wide = SAT_W'(GAIN_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            gain_reg <= GAIN_W'(gain_wide);
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign gain            = gain_reg;
endmodule
`default_nettype wire

// ===== rtl/ddg_ctrl.sv =====
// ddg_ctrl: sequencer for CORDIC steps, store write, pair sweeps, drain and output.
// Depends on ddg_pkg.
`default_nettype none
module ddg_ctrl
    import ddg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire ddg_status_t status,
    output ddg_cmd_t         cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORDIC = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_PAIRS  = 3'd3;
    localparam logic [2:0] S_NEWP   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_MUL    = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(HISTORY_DEPTH - 1);

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [3:0]         step_reg;
    logic [3:0]         step_next;
    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   a_next;
    logic [IDX_W-1:0]   b_reg;
    logic [IDX_W-1:0]   b_next;
    logic [DRAIN_W-1:0] drain_reg;
    logic [DRAIN_W-1:0] drain_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd.step_idx = step_reg;
        cmd.addr_a   = a_reg;
        cmd.addr_b   = b_reg;
        in_ready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    state_next  = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.store_write = 1'b1;
                a_next          = '0;
                b_next          = IDX_W'(1);
                state_next      = S_PAIRS;
            end
            S_PAIRS:
            begin
                cmd.issue = 1'b1;
                if (b_reg == LAST)
                begin
                    if (a_reg == LAST - 1'b1)
                    begin
                        b_next     = '0;
                        state_next = S_NEWP;
                    end
                    else
                    begin
                        a_next = a_reg + 1'b1;
                        b_next = a_reg + IDX_W'(2);
                    end
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
            end
            S_NEWP:
            begin
                cmd.issue    = 1'b1;
                cmd.new_pass = 1'b1;
                b_next       = b_reg + 1'b1;
                if (b_reg == LAST)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            drain_reg <= drain_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/direction_dispersion_gain_unit.sv =====
// direction_dispersion_gain_unit: top level, controller plus datapath.
// Depends on ddg_pkg, ddg_if, ddg_ctrl, ddg_datapath.
//
//  channel   | kind          | payload
//  ----------+---------------+--------------------------------------
//  pos       | sink, v/r     | pos_x, pos_y (signed Q1.15)
//  result    | source, v/r   | gain (27 bit, units of 2^-16)
//  cfg       | write only    | cfg_we, cfg_index, cfg_data (16 bit)
//
// One transaction at a time: accept, the CORDIC steps, one store write, one issue
// per stored pair (D*(D-1)/2) plus D issues for the new-angle pass, the drain,
// one multiply and one output load. The shared decay pipeline is fed a single
// pair at a time, so the unit works through these steps in order.
// The result sits in an output register; a stalled sink only holds the unit
// in its final cycle until the register frees. Reset clears the valid bits of
// the angle store at once, so no clearing pass is needed.
`default_nettype none
module direction_dispersion_gain_unit
    import ddg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ddg_pos_if.sink                   pos,
    ddg_gain_if.source                result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SPREAD_W-1:0]  cfg_data
);
    ddg_cmd_t    cmd;
    ddg_status_t status;

    // sequencer
    ddg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pos.valid),
        .in_ready (pos.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, angle store and output register
    ddg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_x     (pos.pos_x),
        .pos_y     (pos.pos_y),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .gain      (result.gain)
    );
endmodule
`default_nettype wire

// ===== rtl/ddg_checker.sv =====
// ddg_checker: port-level assertions for the direction dispersion gain unit, with bind.
// Depends on ddg_pkg and direction_dispersion_gain_unit.
`default_nettype none
module ddg_checker
    import ddg_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [GAIN_W-1:0] gain
);
    localparam longint GAIN_PEAK_RAW = longint'(PAIRS) * longint'(HISTORY_DEPTH - 1) * 65536;
    localparam longint GAIN_PEAK = (GAIN_PEAK_RAW > GAIN_MAX) ? GAIN_MAX : GAIN_PEAK_RAW;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gain))
        else $error("result dropped or changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // a result never appears straight after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too early");

    // gain within the reachable range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(gain) <= 64'(GAIN_PEAK)))
        else $error("gain beyond its range");
endmodule

bind direction_dispersion_gain_unit ddg_checker u_ddg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pos.valid),
    .in_ready  (pos.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .gain      (result.gain)
);
`default_nettype wire

// ===== tb/direction_dispersion_gain_unit_tb.sv =====
// Self-checking testbench for direction_dispersion_gain_unit: directed table, then random phases.
// Depends on ddg_pkg, ddg_if and the RTL; no files or arguments read.
`timescale 1ns / 1ps
module direction_dispersion_gain_unit_tb;
    import ddg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int IDLE_PCT       = 23;
    localparam int PHASE_ITEMS    = 240;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SPREAD_W-1:0]  cfg_data;

    ddg_pos_if  pos ();
    ddg_gain_if result ();

    direction_dispersion_gain_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: own copy of the angle history and the decay settings
    // ---------------------------------------------------------------
    int          angle_hist [HISTORY_DEPTH];
    int          newest_slot;
    logic [15:0] decay_all;
    logic [15:0] decay_new;

    const longint arctan_deg128 [CORDIC_STEPS] = '{5760, 3400, 1797, 912, 458, 229, 115,
                                                   57, 29, 14, 7, 4, 2, 1};
    const longint exp2_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                     48393, 46341, 44376, 42495, 40694, 38968, 37316,
                                     35734, 34220, 32768};

    // CORDIC vectoring atan2, 1/128 degree
    function automatic int azimuth_of(input longint x, input longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        // pre-rotate the left half plane by a quarter turn
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = QUARTER_TURN;
            end
            else
            begin
                t = x; x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;   // arithmetic shift is a floor shift
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arctan_deg128[i];
            end
            else
            begin
                x -= dx; y += dy; z -= arctan_deg128[i];
            end
        end
        if (z > HALF_TURN)  z -= FULL_TURN;
        if (z < -HALF_TURN) z += FULL_TURN;
        return int'(z);
    endfunction

    // exp(-k*d) in Q1.16 via base-2 exponent and interpolated table
    function automatic longint decay_q16(input longint k, input longint d);
        longint e;
        longint w;
        longint n;
        longint j;
        longint r;
        longint m;
        e = k * d;
        w = (e * LOG2E_Q16 + (64'sd1 <<< 26)) >>> 27;
        n = w >>> 8;
        j = (w >>> 4) & 15;
        r = w & 15;
        if (n >= 17)
            return 0;
        m = exp2_frac[j] - (((exp2_frac[j] - exp2_frac[j + 1]) * r + 8) >>> 4);
        if (n == 0)
            return m;
        return (m + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint predict_gain(input logic signed [POS_W-1:0] x,
                                            input logic signed [POS_W-1:0] y);
        longint total;
        longint current;
        longint g;
        longint d;
        total   = 0;
        current = 0;
        newest_slot = (newest_slot + 1) % HISTORY_DEPTH;
        angle_hist[newest_slot] = azimuth_of(longint'(x), longint'(y));
        for (int a = 0; a + 1 < HISTORY_DEPTH; a++)
            for (int b = a + 1; b < HISTORY_DEPTH; b++)
            begin
                d = angle_hist[a] - angle_hist[b];
                if (d < 0)         d = -d;
                if (d > HALF_TURN) d = FULL_TURN - d;
                total += decay_q16(decay_all, d);
                if (a == newest_slot || b == newest_slot)
                    current += decay_q16(decay_new, d);
            end
        g = (total * current + 32768) >>> 16;
        if (g > GAIN_MAX)
            g = GAIN_MAX;
        return g;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: expected gains in acceptance order
    // ---------------------------------------------------------------
    logic [GAIN_W-1:0] gain_due_q [$];
    longint            typed_gain;   // >= 0 overrides the predictor for a directed row
    int                err_count;
    int                quiet_cycles;
    bit                idling_on;

    always @(posedge clk)
    begin
        longint p;
        if (rst_n)
        begin
            if (pos.valid && pos.ready)
            begin
                p = predict_gain(pos.pos_x, pos.pos_y);
                gain_due_q.push_back(typed_gain >= 0 ? typed_gain[GAIN_W-1:0] : p[GAIN_W-1:0]);
            end
            if (result.valid && result.ready)
            begin
                if (gain_due_q.size() == 0)
                begin
                    $display("%0t: unexpected gain transaction, expected none, actual %0d",
                             $time, result.gain);
                    err_count++;
                end
                else
                begin
                    if (result.gain !== gain_due_q[0])
                    begin
                        $display("%0t: gain mismatch, expected %0d, actual %0d",
                                 $time, gain_due_q[0], result.gain);
                        err_count++;
                    end
                    void'(gain_due_q.pop_front());
                end
            end
            // watchdog: cycles with no transaction on either channel
            if ((pos.valid && pos.ready) || (result.valid && result.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sink side back-pressure, changed on the falling edge
    always @(negedge clk)
        result.ready <= idling_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        longint                  gain;   // -1: taken from the predictor
    } pos_row_t;

    // with an all-zero history every pair is at distance 0: 120 * 15 in Q11.16
    const pos_row_t directed_rows [] = '{
        '{16'sd0,      16'sd0,      117964800},  // zero vector on a cleared store
        '{16'sd32767,  16'sd0,      -1},
        '{-16'sd32768, 16'sd0,      -1},         // opposite direction, half turn
        '{16'sd0,      16'sd32767,  -1},
        '{16'sd0,     -16'sd32768,  -1},
        '{-16'sd32768, -16'sd32768, -1},
        '{16'sd32767,  16'sd32767,  -1},
        '{-16'sd32768, 16'sd32767,  -1},
        '{16'sd32767, -16'sd32768,  -1},
        '{-16'sd1,     16'sd0,      -1},
        '{16'sd0,     -16'sd1,      -1},
        '{16'sd1,      16'sd1,      -1},
        '{-16'sd32768, 16'sd1,      -1},
        '{-16'sd32768, -16'sd1,     -1},
        '{16'sd0,      16'sd0,      -1},
        '{16'sd32767,  16'sd1,      -1},
        '{16'sd32767, -16'sd1,      -1}
    };

    task automatic send_pos(input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y);
        while (idling_on && $urandom_range(99) < IDLE_PCT)
        begin
            pos.valid <= 1'b0;
            @(negedge clk);
        end
        pos.valid <= 1'b1;
        pos.pos_x <= x;
        pos.pos_y <= y;
        do
            @(posedge clk);
        while (!pos.ready);
        @(negedge clk);
    endtask

    // registers only change with nothing in flight; every item gives a gain
    task automatic write_spreads(input logic [15:0] all_k, input logic [15:0] new_k);
        pos.valid <= 1'b0;
        wait (gain_due_q.size() == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPREAD_ALL;
        cfg_data  <= all_k;
        decay_all  = all_k;
        @(negedge clk);
        cfg_index <= REG_SPREAD_NEW;
        cfg_data  <= new_k;
        decay_new  = new_k;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // clustered directions keep close pairs in the history, so the decay
    // table is exercised well away from zero; the rest is full-range noise or zero and most-negative values
    task automatic random_phase(input int count, input bit pause_midway);
        int base_x;
        int base_y;
        int sel;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        base_x = $urandom_range(65535) - 32768;
        base_y = $urandom_range(65535) - 32768;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(9);
            if (sel < 6)
            begin
                x = 16'(base_x + int'($urandom_range(2047)) - 1024);
                y = 16'(base_y + int'($urandom_range(2047)) - 1024);
            end
            else if (sel < 9)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = ($urandom_range(1)) ? 16'sd0 : 16'($urandom);
                y = ($urandom_range(1)) ? 16'sd0 : -16'sd32768;
            end
            if ($urandom_range(19) == 0)
            begin
                base_x = $urandom_range(65535) - 32768;
                base_y = $urandom_range(65535) - 32768;
            end
            if (pause_midway && n == count / 2)
            begin
                // hold the sender off until the unit has drained
                pos.valid <= 1'b0;
                wait (gain_due_q.size() == 0);
                @(negedge clk);
            end
            send_pos(x, y);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SPREAD_ALL;
        cfg_data     = '0;
        pos.valid    = 1'b0;
        pos.pos_x    = '0;
        pos.pos_y    = '0;
        result.ready = 1'b0;
        err_count    = 0;
        quiet_cycles = 0;
        idling_on    = 1'b1;
        typed_gain   = -1;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            angle_hist[i] = 0;
        newest_slot = HISTORY_DEPTH - 1;
        decay_all   = SPREAD_RESET;
        decay_new   = SPREAD_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows at the reset spreads
        foreach (directed_rows[i])
        begin
            typed_gain = directed_rows[i].gain;
            send_pos(directed_rows[i].x, directed_rows[i].y);
        end
        typed_gain = -1;

        // random phases across spread settings, extremes included
        write_spreads(16'd0, 16'd0);
        random_phase(PHASE_ITEMS, 1'b0);
        write_spreads(16'hFFFF, 16'hFFFF);
        random_phase(PHASE_ITEMS, 1'b1);
        write_spreads(16'd1, 16'hFFFF);
        idling_on = 1'b0;   // long stretch without any idling
        random_phase(PHASE_ITEMS, 1'b0);
        idling_on = 1'b1;
        write_spreads(16'($urandom), 16'($urandom));
        random_phase(PHASE_ITEMS, 1'b0);
        write_spreads(16'd410, 16'($urandom_range(2000)));
        random_phase(PHASE_ITEMS, 1'b0);

        pos.valid <= 1'b0;
        wait (gain_due_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ddg_pkg.sv
rtl/ddg_if.sv
rtl/ddg_decay.sv
rtl/ddg_datapath.sv
rtl/ddg_ctrl.sv
rtl/direction_dispersion_gain_unit.sv
rtl/ddg_checker.sv
tb/direction_dispersion_gain_unit_tb.sv
